// ----- rtl/core/tkd_pkg.sv -----
// types, constants and codes shared by the terminal key decoder
package tkd_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CP_BITS    = 21;
    localparam int FIFO_DEPTH = 4;
    localparam int MAX_KEYS   = 3;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd25;

    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_CR      = 8'h0d;
    localparam logic [7:0] BYTE_DEL     = 8'h7f;
    localparam logic [7:0] BYTE_BRACKET = 8'h5b;
    localparam logic [7:0] BYTE_UP      = 8'h41;
    localparam logic [7:0] BYTE_DOWN    = 8'h42;
    localparam logic [7:0] BYTE_RIGHT   = 8'h43;
    localparam logic [7:0] BYTE_LEFT    = 8'h44;
    localparam logic [7:0] BYTE_HOME    = 8'h48;
    localparam logic [7:0] BYTE_END     = 8'h46;

    localparam logic [CP_BITS-1:0] CP_REPLACEMENT = 21'h00fffd;
    localparam logic [CP_BITS-1:0] CP_MAX         = 21'h10ffff;
    localparam logic [CP_BITS-1:0] CP_SURR_LO     = 21'h00d800;
    localparam logic [CP_BITS-1:0] CP_SURR_HI     = 21'h00dfff;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_EOS  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ESC     = 2'd1,
        MODE_BRACKET = 2'd2,
        MODE_UTF8    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        KIND_RUNE      = 4'd0,
        KIND_ESC       = 4'd1,
        KIND_ENTER     = 4'd2,
        KIND_BACKSPACE = 4'd3,
        KIND_UP        = 4'd4,
        KIND_DOWN      = 4'd5,
        KIND_RIGHT     = 4'd6,
        KIND_LEFT      = 4'd7,
        KIND_HOME      = 4'd8,
        KIND_END       = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CP_BITS-1:0] cp;
    } key_t;

    typedef struct packed {
        mode_t                 mode;
        logic [1:0]            remaining;
        logic [CP_BITS-1:0]    acc;
        logic                  cont_ok;
        logic [TIMER_BITS-1:0] timer;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]   count;
        key_t [MAX_KEYS-1:0] keys;
    } step_res_t;

    localparam dec_state_t IDLE_STATE = '{
        mode:      MODE_IDLE,
        remaining: 2'd0,
        acc:       '0,
        cont_ok:   1'b1,
        timer:     '0
    };

endpackage

// ----- rtl/core/tkd_event_if.sv -----
// channel carrying terminal events into the decoder
interface tkd_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// ----- rtl/core/tkd_key_if.sv -----
// channel carrying decoded key events out of the decoder
interface tkd_key_if;
    logic        valid;
    logic        ready;
    logic [3:0]  key_kind;
    logic [20:0] code_point;
    logic        last;

    modport source (output valid, output key_kind, output code_point, output last, input ready);
    modport sink   (input valid, input key_kind, input code_point, input last, output ready);
endinterface

// ----- rtl/core/tkd_step.sv -----
// next-state and key logic for one terminal event
module tkd_step (
    input  tkd_pkg::dec_state_t        state,
    input  logic [1:0]                 op,
    input  logic [7:0]                 data_byte,
    input  logic [tkd_pkg::CFG_BITS-1:0] timeout_ticks,
    output tkd_pkg::dec_state_t        state_next,
    output tkd_pkg::step_res_t         res
);

    typedef struct packed {
        logic                emit;
        tkd_pkg::key_t       key;
        tkd_pkg::mode_t      mode;
        logic [1:0]          remaining;
        logic [tkd_pkg::CP_BITS-1:0] acc;
    } fresh_t;

    function automatic fresh_t fresh_byte(input logic [7:0] b);
        fresh_t f;
        f           = '0;
        f.mode      = tkd_pkg::MODE_IDLE;
        f.key.kind  = tkd_pkg::KIND_RUNE;
        f.key.cp    = '0;
        if (b == tkd_pkg::BYTE_ESC)
        begin
            f.mode = tkd_pkg::MODE_ESC;
        end
        else if (b == tkd_pkg::BYTE_CR)
        begin
            f.emit     = 1'b1;
            f.key.kind = tkd_pkg::KIND_ENTER;
        end
        else if (b == tkd_pkg::BYTE_DEL)
        begin
            f.emit     = 1'b1;
            f.key.kind = tkd_pkg::KIND_BACKSPACE;
        end
        else if (b[7] == 1'b0)
        begin
            f.emit   = 1'b1;
            f.key.cp = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            f.mode      = tkd_pkg::MODE_UTF8;
            f.remaining = 2'd1;
            f.acc       = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            f.mode      = tkd_pkg::MODE_UTF8;
            f.remaining = 2'd2;
            f.acc       = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            f.mode      = tkd_pkg::MODE_UTF8;
            f.remaining = 2'd3;
            f.acc       = {18'd0, b[2:0]};
        end
        else
        begin
            f.emit   = 1'b1;
            f.key.cp = tkd_pkg::CP_REPLACEMENT;
        end
        return f;
    endfunction

    function automatic tkd_pkg::key_t make_key(input tkd_pkg::kind_t kind,
                                               input logic [tkd_pkg::CP_BITS-1:0] cp);
        tkd_pkg::key_t k;
        k.kind = kind;
        k.cp   = cp;
        return k;
    endfunction

    localparam logic [tkd_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

    fresh_t                          fr;
    logic [tkd_pkg::CP_BITS-1:0]     acc_shift;
    logic                            cont_ok_upd;
    logic [1:0]                      rem_upd;
    logic [tkd_pkg::CP_BITS-1:0]     utf_cp;
    logic [tkd_pkg::TIMER_BITS-1:0]  timer_upd;
    logic                            fire;
    tkd_pkg::kind_t                  arrow_kind;
    logic                            arrow_hit;
    logic [1:0]                      n;

    assign fr          = fresh_byte(data_byte);
    assign acc_shift   = {state.acc[tkd_pkg::CP_BITS-7:0], data_byte[5:0]};
    assign cont_ok_upd = state.cont_ok && (data_byte[7:6] == 2'b10);
    assign rem_upd     = (state.remaining != 2'd0) ? state.remaining - 2'd1 : state.remaining;
    assign timer_upd   = (state.timer != TIMER_MAX) ? state.timer + 1'b1 : state.timer;
    assign fire        = ({{(32-tkd_pkg::TIMER_BITS){1'b0}}, timer_upd}
                          >= {{(32-tkd_pkg::CFG_BITS){1'b0}}, timeout_ticks})
                         || (timer_upd == TIMER_MAX);

    always_comb
    begin
        if (!cont_ok_upd)
        begin
            utf_cp = tkd_pkg::CP_REPLACEMENT;
        end
        else if (acc_shift > tkd_pkg::CP_MAX ||
                 (acc_shift >= tkd_pkg::CP_SURR_LO && acc_shift <= tkd_pkg::CP_SURR_HI))
        begin
            utf_cp = tkd_pkg::CP_REPLACEMENT;
        end
        else
        begin
            utf_cp = acc_shift;
        end
    end

    always_comb
    begin
        arrow_hit  = 1'b1;
        arrow_kind = tkd_pkg::KIND_UP;
        unique case (data_byte)
            tkd_pkg::BYTE_UP:    arrow_kind = tkd_pkg::KIND_UP;
            tkd_pkg::BYTE_DOWN:  arrow_kind = tkd_pkg::KIND_DOWN;
            tkd_pkg::BYTE_RIGHT: arrow_kind = tkd_pkg::KIND_RIGHT;
            tkd_pkg::BYTE_LEFT:  arrow_kind = tkd_pkg::KIND_LEFT;
            tkd_pkg::BYTE_HOME:  arrow_kind = tkd_pkg::KIND_HOME;
            tkd_pkg::BYTE_END:   arrow_kind = tkd_pkg::KIND_END;
            default:             arrow_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state;
        res        = '0;
        n          = 2'd0;
        unique case (tkd_pkg::op_t'(op))
            tkd_pkg::OP_BYTE:
            begin
                unique case (state.mode)
                    tkd_pkg::MODE_IDLE:
                    begin
                        state_next           = tkd_pkg::IDLE_STATE;
                        state_next.mode      = fr.mode;
                        state_next.remaining = fr.remaining;
                        state_next.acc       = fr.acc;
                        if (fr.emit)
                        begin
                            res.keys[n] = fr.key;
                            n           = n + 2'd1;
                        end
                    end
                    tkd_pkg::MODE_ESC:
                    begin
                        if (data_byte == tkd_pkg::BYTE_BRACKET)
                        begin
                            state_next.mode  = tkd_pkg::MODE_BRACKET;
                            state_next.timer = '0;
                        end
                        else
                        begin
                            res.keys[n] = make_key(tkd_pkg::KIND_ESC, '0);
                            n           = n + 2'd1;
                            state_next           = tkd_pkg::IDLE_STATE;
                            state_next.mode      = fr.mode;
                            state_next.remaining = fr.remaining;
                            state_next.acc       = fr.acc;
                            if (fr.emit)
                            begin
                                res.keys[n] = fr.key;
                                n           = n + 2'd1;
                            end
                        end
                    end
                    tkd_pkg::MODE_BRACKET:
                    begin
                        state_next = tkd_pkg::IDLE_STATE;
                        if (arrow_hit)
                        begin
                            res.keys[n] = make_key(arrow_kind, '0);
                            n           = n + 2'd1;
                        end
                        else
                        begin
                            res.keys[n] = make_key(tkd_pkg::KIND_ESC, '0);
                            n           = n + 2'd1;
                            res.keys[n] = make_key(tkd_pkg::KIND_RUNE,
                                                   {13'd0, tkd_pkg::BYTE_BRACKET});
                            n           = n + 2'd1;
                            state_next.mode      = fr.mode;
                            state_next.remaining = fr.remaining;
                            state_next.acc       = fr.acc;
                            if (fr.emit)
                            begin
                                res.keys[n] = fr.key;
                                n           = n + 2'd1;
                            end
                        end
                    end
                    tkd_pkg::MODE_UTF8:
                    begin
                        state_next.cont_ok   = cont_ok_upd;
                        state_next.acc       = acc_shift;
                        state_next.remaining = rem_upd;
                        if (rem_upd == 2'd0)
                        begin
                            state_next  = tkd_pkg::IDLE_STATE;
                            res.keys[n] = make_key(tkd_pkg::KIND_RUNE, utf_cp);
                            n           = n + 2'd1;
                        end
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            tkd_pkg::OP_TICK:
            begin
                if (state.mode == tkd_pkg::MODE_ESC || state.mode == tkd_pkg::MODE_BRACKET)
                begin
                    state_next.timer = timer_upd;
                    if (fire)
                    begin
                        state_next  = tkd_pkg::IDLE_STATE;
                        res.keys[n] = make_key(tkd_pkg::KIND_ESC, '0);
                        n           = n + 2'd1;
                        if (state.mode == tkd_pkg::MODE_BRACKET)
                        begin
                            res.keys[n] = make_key(tkd_pkg::KIND_RUNE,
                                                   {13'd0, tkd_pkg::BYTE_BRACKET});
                            n           = n + 2'd1;
                        end
                    end
                end
            end
            tkd_pkg::OP_EOS:
            begin
                state_next = tkd_pkg::IDLE_STATE;
                if (state.mode == tkd_pkg::MODE_ESC || state.mode == tkd_pkg::MODE_BRACKET)
                begin
                    res.keys[n] = make_key(tkd_pkg::KIND_ESC, '0);
                    n           = n + 2'd1;
                end
                if (state.mode == tkd_pkg::MODE_BRACKET)
                begin
                    res.keys[n] = make_key(tkd_pkg::KIND_RUNE,
                                           {13'd0, tkd_pkg::BYTE_BRACKET});
                    n           = n + 2'd1;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        res.count = n;
    end

endmodule

// ----- rtl/core/terminal_key_decoder.sv -----
// top level of the terminal key decoder
//
// events: valid/ready channel of terminal events; op selects a byte, a timer
// tick, end of stream or no operation, data_byte carries the byte.
// keys: valid/ready channel of key events (key_kind, code_point); last marks
// the final key caused by one event, which may cause zero to three keys.
// cfg_we/cfg_wdata write the escape timeout in ticks; write only while idle.
// An accepted event is held in the input register until the decode logic
// takes it, updates the decoder state and pushes its keys into a four-entry
// output queue; the first key is offered on keys in the cycle after the push.
// Throughput is one event per cycle as long as each event causes at most
// one key and keys.ready stays high; several keys of one event leave the queue one at a time.
// The input register advances only when the queue has room for all keys of
// its event, so a stalled receiver fills the queue and then holds events off.
// Reset puts the decoder idle, empties the queue and sets the timeout to 25.
module terminal_key_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    tkd_event_if.sink                     events,
    tkd_key_if.source                     keys,
    input  logic                          cfg_we,
    input  logic [tkd_pkg::CFG_BITS-1:0]  cfg_wdata
);

    typedef struct packed {
        tkd_pkg::key_t key;
        logic          last;
    } entry_t;

    logic [tkd_pkg::CFG_BITS-1:0] timeout_reg;
    tkd_pkg::dec_state_t          state_reg;
    tkd_pkg::dec_state_t          state_next;
    tkd_pkg::step_res_t           res;

    logic                         in_vld_reg;
    logic [1:0]                   in_op_reg;
    logic [7:0]                   in_byte_reg;

    entry_t                       fifo_reg [tkd_pkg::FIFO_DEPTH];
    logic [1:0]                   wr_ptr_reg;
    logic [1:0]                   rd_ptr_reg;
    logic [2:0]                   count_reg;
    logic [2:0]                   count_next;

    logic                         fire;
    logic                         pop;
    logic                         accept;

    tkd_step u_step (
        .state         (state_reg),
        .op            (in_op_reg),
        .data_byte     (in_byte_reg),
        .timeout_ticks (timeout_reg),
        .state_next    (state_next),
        .res           (res)
    );

    assign fire   = in_vld_reg && ((count_reg + {1'b0, res.count}) <= 3'(tkd_pkg::FIFO_DEPTH));
    assign accept = events.valid && events.ready;
    assign pop    = keys.valid && keys.ready;

    assign events.ready = !in_vld_reg || fire;

    assign keys.valid      = (count_reg != 3'd0);
    assign keys.key_kind   = fifo_reg[rd_ptr_reg].key.kind;
    assign keys.code_point = fifo_reg[rd_ptr_reg].key.cp;
    assign keys.last       = fifo_reg[rd_ptr_reg].last;

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            count_next = count_next + {1'b0, res.count};
        end
        if (pop)
        begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tkd_pkg::TIMEOUT_RESET;
            state_reg   <= tkd_pkg::IDLE_STATE;
            in_vld_reg  <= 1'b0;
            wr_ptr_reg  <= 2'd0;
            rd_ptr_reg  <= 2'd0;
            count_reg   <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end
            if (fire)
            begin
                state_reg  <= state_next;
                wr_ptr_reg <= wr_ptr_reg + res.count;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= events.op;
            in_byte_reg <= events.data_byte;
        end
        if (fire)
        begin
            for (int i = 0; i < tkd_pkg::MAX_KEYS; i++)
            begin
                if (2'(i) < res.count)
                begin
                    fifo_reg[wr_ptr_reg + 2'(i)].key  <= res.keys[i];
                    fifo_reg[wr_ptr_reg + 2'(i)].last <= (2'(i) == (res.count - 2'd1));
                end
            end
        end
    end

endmodule

// ----- verif/terminal_key_decoder_test.sv -----
// self-checking testbench for the terminal key decoder
`timescale 1ns / 100ps

module terminal_key_decoder_test;

    typedef logic [tkd_pkg::CP_BITS-1:0]    cp_t;
    typedef logic [tkd_pkg::CFG_BITS-1:0]   cfg_t;
    typedef logic [tkd_pkg::TIMER_BITS-1:0] ticks_t;

    typedef struct {
        tkd_pkg::op_t op;
        logic [7:0]   data;
    } event_beat_t;

    typedef struct {
        tkd_pkg::kind_t kind;
        cp_t            cp;
        logic           last;
    } key_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_t cfg_wdata;

    tkd_event_if ev ();
    tkd_key_if   kv ();

    terminal_key_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev),
        .keys      (kv),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    event_beat_t pending_events[$];
    key_beat_t   keys_expected[$];
    key_beat_t   step_keys[$];

    tkd_pkg::mode_t dec_mode;
    logic [1:0]     cont_left;
    cp_t            code_acc;
    logic           cont_good;
    ticks_t         esc_ticks;
    cfg_t           timeout_ticks;

    int   err_count;
    int   items_pushed;
    bit   idling_on;
    bit   beat_taken;
    int   ev_gap;
    int   rdy_gap;
    event_beat_t cur_event;
    key_beat_t   want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void add_key(tkd_pkg::kind_t k, cp_t cp);
        key_beat_t kb;
        kb.kind = k;
        kb.cp   = cp;
        kb.last = 1'b0;
        step_keys.push_back(kb);
    endfunction

    function automatic void go_idle();
        dec_mode  = tkd_pkg::MODE_IDLE;
        cont_left = 2'd0;
        code_acc  = '0;
        cont_good = 1'b1;
        esc_ticks = '0;
    endfunction

    function automatic cp_t legal_scalar(cp_t cp);
        if (cp > tkd_pkg::CP_MAX || (cp >= tkd_pkg::CP_SURR_LO && cp <= tkd_pkg::CP_SURR_HI))
            return tkd_pkg::CP_REPLACEMENT;
        return cp;
    endfunction

    function automatic void start_seq(logic [1:0] n, cp_t bits);
        dec_mode  = tkd_pkg::MODE_UTF8;
        cont_left = n;
        code_acc  = bits;
        cont_good = 1'b1;
    endfunction

    function automatic void take_fresh(logic [7:0] b);
        if (b == tkd_pkg::BYTE_ESC)
        begin
            dec_mode  = tkd_pkg::MODE_ESC;
            esc_ticks = '0;
        end
        else if (b == tkd_pkg::BYTE_CR)
            add_key(tkd_pkg::KIND_ENTER, '0);
        else if (b == tkd_pkg::BYTE_DEL)
            add_key(tkd_pkg::KIND_BACKSPACE, '0);
        else if (b < 8'h80)
            add_key(tkd_pkg::KIND_RUNE, cp_t'(b));
        else if ((b & 8'he0) == 8'hc0)
            start_seq(2'd1, cp_t'(b & 8'h1f));
        else if ((b & 8'hf0) == 8'he0)
            start_seq(2'd2, cp_t'(b & 8'h0f));
        else if ((b & 8'hf8) == 8'hf0)
            start_seq(2'd3, cp_t'(b & 8'h07));
        else
            add_key(tkd_pkg::KIND_RUNE, tkd_pkg::CP_REPLACEMENT);
    endfunction

    function automatic void predict_event(tkd_pkg::op_t op, logic [7:0] b);
        tkd_pkg::mode_t was;
        tkd_pkg::kind_t arrow;
        logic           hit;
        cp_t            cp;
        step_keys.delete();
        case (op)
            tkd_pkg::OP_BYTE:
                case (dec_mode)
                    tkd_pkg::MODE_IDLE:
                        take_fresh(b);
                    tkd_pkg::MODE_ESC:
                        if (b == tkd_pkg::BYTE_BRACKET)
                        begin
                            dec_mode  = tkd_pkg::MODE_BRACKET;
                            esc_ticks = '0;
                        end
                        else
                        begin
                            add_key(tkd_pkg::KIND_ESC, '0);
                            go_idle();
                            take_fresh(b);
                        end
                    tkd_pkg::MODE_BRACKET:
                    begin
                        hit   = 1'b1;
                        arrow = tkd_pkg::KIND_UP;
                        case (b)
                            tkd_pkg::BYTE_UP:    arrow = tkd_pkg::KIND_UP;
                            tkd_pkg::BYTE_DOWN:  arrow = tkd_pkg::KIND_DOWN;
                            tkd_pkg::BYTE_RIGHT: arrow = tkd_pkg::KIND_RIGHT;
                            tkd_pkg::BYTE_LEFT:  arrow = tkd_pkg::KIND_LEFT;
                            tkd_pkg::BYTE_HOME:  arrow = tkd_pkg::KIND_HOME;
                            tkd_pkg::BYTE_END:   arrow = tkd_pkg::KIND_END;
                            default:             hit = 1'b0;
                        endcase
                        go_idle();
                        if (hit)
                            add_key(arrow, '0);
                        else
                        begin
                            add_key(tkd_pkg::KIND_ESC, '0);
                            add_key(tkd_pkg::KIND_RUNE, cp_t'(tkd_pkg::BYTE_BRACKET));
                            take_fresh(b);
                        end
                    end
                    default:
                    begin
                        if (b[7:6] != 2'b10)
                            cont_good = 1'b0;
                        code_acc = {code_acc[tkd_pkg::CP_BITS-7:0], b[5:0]};
                        if (cont_left != 2'd0)
                            cont_left = cont_left - 2'd1;
                        if (cont_left == 2'd0)
                        begin
                            cp = cont_good ? legal_scalar(code_acc) : tkd_pkg::CP_REPLACEMENT;
                            go_idle();
                            add_key(tkd_pkg::KIND_RUNE, cp);
                        end
                    end
                endcase
            tkd_pkg::OP_TICK:
                if (dec_mode == tkd_pkg::MODE_ESC || dec_mode == tkd_pkg::MODE_BRACKET)
                begin
                    if (esc_ticks != '1)
                        esc_ticks = esc_ticks + 1'b1;
                    if (esc_ticks >= timeout_ticks || esc_ticks == '1)
                    begin
                        was = dec_mode;
                        go_idle();
                        add_key(tkd_pkg::KIND_ESC, '0);
                        if (was == tkd_pkg::MODE_BRACKET)
                            add_key(tkd_pkg::KIND_RUNE, cp_t'(tkd_pkg::BYTE_BRACKET));
                    end
                end
            tkd_pkg::OP_EOS:
            begin
                was = dec_mode;
                go_idle();
                if (was == tkd_pkg::MODE_ESC)
                    add_key(tkd_pkg::KIND_ESC, '0);
                else if (was == tkd_pkg::MODE_BRACKET)
                begin
                    add_key(tkd_pkg::KIND_ESC, '0);
                    add_key(tkd_pkg::KIND_RUNE, cp_t'(tkd_pkg::BYTE_BRACKET));
                end
            end
            default: ;
        endcase
        if (step_keys.size() > 0)
            step_keys[step_keys.size()-1].last = 1'b1;
        foreach (step_keys[i])
            keys_expected.push_back(step_keys[i]);
    endfunction

    // acceptance, prediction and checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (kv.valid && kv.ready)
            begin
                if (keys_expected.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected key: kind %0d cp %h last %0d",
                                 kv.key_kind, kv.code_point, kv.last);
                    err_count++;
                end
                else
                begin
                    want = keys_expected.pop_front();
                    if (kv.key_kind != want.kind || kv.code_point != want.cp ||
                        kv.last != want.last)
                    begin
                        if (err_count < 10)
                            $display({"key mismatch: expected kind %0d cp %h last %0d, ",
                                      "got kind %0d cp %h last %0d"},
                                     want.kind, want.cp, want.last,
                                     kv.key_kind, kv.code_point, kv.last);
                        err_count++;
                    end
                end
            end
            if (ev.valid && ev.ready)
            begin
                predict_event(tkd_pkg::op_t'(ev.op), ev.data_byte);
                beat_taken = 1'b1;
            end
        end
    end

    // event driver
    always @(negedge clk)
    begin
        if (rst_n && (!ev.valid || beat_taken))
        begin
            if (ev_gap > 0)
            begin
                ev_gap--;
                ev.valid <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                ev_gap = $urandom_range(0, 6);
                ev.valid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                cur_event = pending_events.pop_front();
                ev.valid     <= 1'b1;
                ev.op        <= cur_event.op;
                ev.data_byte <= cur_event.data;
            end
            else
                ev.valid <= 1'b0;
        end
        beat_taken = 1'b0;
    end

    // key sink backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rdy_gap > 0)
            begin
                rdy_gap--;
                kv.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rdy_gap = $urandom_range(0, 6);
                kv.ready <= 1'b0;
            end
            else
                kv.ready <= 1'b1;
        end
    end

    task automatic push_event(tkd_pkg::op_t op, logic [7:0] b, bit counted);
        event_beat_t e;
        e.op   = op;
        e.data = b;
        pending_events.push_back(e);
        if (counted)
            items_pushed++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_event(tkd_pkg::OP_BYTE, b, 1'b1);
    endtask

    task automatic wait_drain();
        while (pending_events.size() != 0 || ev.valid || keys_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_timeout(cfg_t v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we        = 1'b0;
        timeout_ticks = v;
    endtask

    function automatic logic [7:0] pick_arrow();
        case ($urandom_range(0, 5))
            0:       return tkd_pkg::BYTE_UP;
            1:       return tkd_pkg::BYTE_DOWN;
            2:       return tkd_pkg::BYTE_RIGHT;
            3:       return tkd_pkg::BYTE_LEFT;
            4:       return tkd_pkg::BYTE_HOME;
            default: return tkd_pkg::BYTE_END;
        endcase
    endfunction

    task automatic gen_random(int target);
        int r;
        int n;
        int len;
        logic [7:0] b;
        items_pushed = 0;
        while (items_pushed < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                push_byte(tkd_pkg::BYTE_ESC);
                push_byte(tkd_pkg::BYTE_BRACKET);
                push_byte(pick_arrow());
            end
            else if (r < 30)
            begin
                push_byte(tkd_pkg::BYTE_ESC);
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 38)
            begin
                push_byte(tkd_pkg::BYTE_ESC);
                push_byte(tkd_pkg::BYTE_BRACKET);
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 48)
            begin
                push_byte(tkd_pkg::BYTE_ESC);
                if ($urandom_range(0, 1))
                    push_byte(tkd_pkg::BYTE_BRACKET);
                if (timeout_ticks <= 40)
                    n = $urandom_range(0, timeout_ticks + 1);
                else
                    n = $urandom_range(0, 4);
                repeat (n) push_event(tkd_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 70)
            begin
                len = $urandom_range(1, 3);
                case (len)
                    1:       push_byte(8'hc0 | 8'($urandom_range(0, 31)));
                    2:       push_byte(8'he0 | 8'($urandom_range(0, 15)));
                    default: push_byte(8'hf0 | 8'($urandom_range(0, 7)));
                endcase
                repeat (len)
                begin
                    if ($urandom_range(0, 5) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = 8'h80 | 8'($urandom_range(0, 63));
                    push_byte(b);
                end
            end
            else if (r < 80)
                push_byte(8'($urandom_range(0, 127)));
            else if (r < 85)
                push_byte($urandom_range(0, 1) ? tkd_pkg::BYTE_CR : tkd_pkg::BYTE_DEL);
            else if (r < 92)
                push_byte(8'($urandom_range(0, 255)));
            else if (r < 96)
                repeat ($urandom_range(1, 3))
                    push_event(tkd_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
            else if (r < 98)
                push_event(tkd_pkg::OP_EOS, 8'($urandom_range(0, 255)), 1'b1);
            else
                push_event(tkd_pkg::OP_NONE, 8'($urandom_range(0, 255)), 1'b0);
        end
        push_event(tkd_pkg::OP_EOS, 8'h00, 1'b1);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        ev.valid     = 1'b0;
        ev.op        = tkd_pkg::OP_BYTE;
        ev.data_byte = 8'h00;
        kv.ready     = 1'b0;
        err_count    = 0;
        items_pushed = 0;
        idling_on    = 1'b1;
        beat_taken   = 1'b0;
        ev_gap       = 0;
        rdy_gap      = 0;
        timeout_ticks = tkd_pkg::TIMEOUT_RESET;
        go_idle();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: plain keys, arrows, broken escapes, bad utf-8, end of stream, escape timeout
        push_byte(8'h00);
        push_byte(tkd_pkg::BYTE_CR);
        push_byte(tkd_pkg::BYTE_DEL);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(tkd_pkg::BYTE_BRACKET);
        push_byte(tkd_pkg::BYTE_UP);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(tkd_pkg::BYTE_BRACKET);
        push_byte(tkd_pkg::BYTE_END);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(8'h78);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(tkd_pkg::BYTE_BRACKET); push_byte(8'h5a);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(tkd_pkg::BYTE_BRACKET);
        push_byte(tkd_pkg::BYTE_ESC);
        push_event(tkd_pkg::OP_EOS, 8'hff, 1'b1);
        push_byte(8'hff);
        push_byte(8'h80);
        push_byte(8'hf4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hed); push_byte(8'ha0); push_byte(8'h80);
        push_byte(8'hc3); push_byte(tkd_pkg::BYTE_ESC);
        push_byte(8'hf0); push_byte(8'h9f); push_byte(8'h98); push_byte(8'h80);
        push_byte(8'hc3); push_event(tkd_pkg::OP_EOS, 8'h00, 1'b1);
        push_event(tkd_pkg::OP_TICK, 8'h00, 1'b1);
        push_event(tkd_pkg::OP_NONE, 8'h55, 1'b1);
        push_byte(tkd_pkg::BYTE_ESC); push_event(tkd_pkg::OP_EOS, 8'h00, 1'b1);
        push_byte(tkd_pkg::BYTE_ESC);
        repeat (25) push_event(tkd_pkg::OP_TICK, 8'h00, 1'b0);
        wait_drain();

        gen_random(60);
        wait_drain();

        write_timeout(16'd1);
        push_byte(tkd_pkg::BYTE_ESC); push_byte(tkd_pkg::BYTE_BRACKET);
        push_event(tkd_pkg::OP_TICK, 8'h00, 1'b1);
        gen_random(60);
        wait_drain();

        write_timeout(16'hffff);
        gen_random(40);
        wait_drain();
        // escape held until the timer saturates at the largest timeout
        idling_on = 1'b0;
        push_byte(tkd_pkg::BYTE_ESC);
        repeat (65535) push_event(tkd_pkg::OP_TICK, 8'h00, 1'b0);
        wait_drain();
        idling_on = 1'b1;

        write_timeout(cfg_t'($urandom_range(2, 40)));
        gen_random(80);
        wait_drain();

        write_timeout(16'd3);
        idling_on = 1'b0;
        gen_random(50);
        wait_drain();

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
